// ----- hw/rtl/shse_pkg.sv -----
// ----------------------------------------------------------------------------
// shse_pkg
// Shared types, constants and the Salsa round functions of the hash and
// symbol engine.
// ----------------------------------------------------------------------------
`default_nettype none

package shse_pkg;

  localparam int DoubleRoundsDefault = 6;
  localparam int QDepth = 2;
  localparam int QAddrW = $clog2(QDepth);

  localparam logic [4:0] SymBitsReset = 5'd8;
  localparam logic [4:0] SymBitsMax   = 5'd16;

  localparam logic ActHash   = 1'b0;
  localparam logic ActSymbol = 1'b1;

  localparam logic [31:0] Tau0 = 32'h61707865;
  localparam logic [31:0] Tau1 = 32'h3120646e;
  localparam logic [31:0] Tau2 = 32'h79622d36;
  localparam logic [31:0] Tau3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef word_t [3:0] quad_t;

  typedef struct packed {
    logic        action;
    logic [63:0] seed;
    logic [31:0] data;
    logic [9:0]  point_index;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest;
    logic [15:0] symbol;
    logic        index_error;
  } out_word_t;

  typedef struct packed {
    logic        action;
    logic [63:0] seed;
    logic [31:0] data;
    logic        err;
    logic [2:0]  word_ind;
    logic [5:0]  shift;
    logic [15:0] mask;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINISH
  } bk_state_t;

  // symbols per 64-bit word
  function automatic logic [6:0] per_word(input logic [4:0] b);
    logic [6:0] pw;
    unique case (b) inside
      5'd1:                  pw = 7'd64;
      5'd2:                  pw = 7'd32;
      5'd3:                  pw = 7'd21;
      5'd4:                  pw = 7'd16;
      5'd5:                  pw = 7'd12;
      5'd6:                  pw = 7'd10;
      5'd7:                  pw = 7'd9;
      5'd8:                  pw = 7'd8;
      5'd9:                  pw = 7'd7;
      5'd10:                 pw = 7'd6;
      5'd11, 5'd12:          pw = 7'd5;
      [5'd13:5'd16]:         pw = 7'd4;
      default:               pw = 7'd64;
    endcase
    return pw;
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned c);
    return (v << c) | (v >> (32 - c));
  endfunction

  function automatic quad_t quarter(input word_t a, input word_t b,
                                    input word_t c, input word_t d);
    word_t a2, b2, c2, d2, s;
    s  = a + d;
    b2 = b ^ rotl(s, 7);
    s  = b2 + a;
    c2 = c ^ rotl(s, 9);
    s  = c2 + b2;
    d2 = d ^ rotl(s, 13);
    s  = d2 + c2;
    a2 = a ^ rotl(s, 18);
    return {d2, c2, b2, a2};
  endfunction

  // one Salsa round: column round when row is low, row round otherwise
  function automatic state_t salsa_round(input state_t x, input logic row);
    state_t y;
    quad_t  q;
    y = x;
    if (!row) begin
      q = quarter(y[0], y[4], y[8], y[12]);
      y[0] = q[0]; y[4] = q[1]; y[8] = q[2]; y[12] = q[3];
      q = quarter(y[5], y[9], y[13], y[1]);
      y[5] = q[0]; y[9] = q[1]; y[13] = q[2]; y[1] = q[3];
      q = quarter(y[10], y[14], y[2], y[6]);
      y[10] = q[0]; y[14] = q[1]; y[2] = q[2]; y[6] = q[3];
      q = quarter(y[15], y[3], y[7], y[11]);
      y[15] = q[0]; y[3] = q[1]; y[7] = q[2]; y[11] = q[3];
    end else begin
      q = quarter(y[0], y[1], y[2], y[3]);
      y[0] = q[0]; y[1] = q[1]; y[2] = q[2]; y[3] = q[3];
      q = quarter(y[5], y[6], y[7], y[4]);
      y[5] = q[0]; y[6] = q[1]; y[7] = q[2]; y[4] = q[3];
      q = quarter(y[10], y[11], y[8], y[9]);
      y[10] = q[0]; y[11] = q[1]; y[8] = q[2]; y[9] = q[3];
      q = quarter(y[15], y[12], y[13], y[14]);
      y[15] = q[0]; y[12] = q[1]; y[13] = q[2]; y[14] = q[3];
    end
    return y;
  endfunction

  function automatic state_t init_state(input logic [63:0] seed,
                                        input logic [31:0] data);
    state_t x;
    x[0]  = Tau0;
    x[5]  = Tau1;
    x[10] = Tau2;
    x[15] = Tau3;
    for (int k = 0; k < 4; k++) begin
      x[1 + k]  = {16'd0, seed[16*k +: 16]};
      x[11 + k] = {16'd0, seed[16*k +: 16]};
    end
    x[6] = data;
    x[7] = data;
    x[8] = '0;
    x[9] = '0;
    return x;
  endfunction

  function automatic logic [63:0] fold_digest(input state_t x);
    word_t lo, hi;
    lo = '0;
    hi = '0;
    for (int k = 0; k < 8; k++) begin
      lo = lo ^ x[2*k];
      hi = hi ^ x[2*k + 1];
    end
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/salsa_hash_symbol_engine_unit.sv -----
// ----------------------------------------------------------------------------
// salsa_hash_symbol_engine_unit
// Salsa hash and symbol engine: front decoder, command queue, round engine.
// ----------------------------------------------------------------------------
// Symbol read: the command passes through the queue and the output register;
//   one word per cycle while no hash is running and the output is not stalled.
// Hash: the round engine runs one Salsa round per cycle, the first as the
//   command is popped, then adds back the input state when the output is free.
// Reset: stored words and digest zero, symbol width 8, queue empty.
`default_nettype none

module salsa_hash_symbol_engine_unit #(
  parameter int DOUBLE_ROUNDS = shse_pkg::DoubleRoundsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [4:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire shse_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output shse_pkg::out_word_t      out_word
);
  import shse_pkg::*;

  cmd_t push_cmd;
  cmd_t q_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  shse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  shse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  shse_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/shse_front.sv -----
// ----------------------------------------------------------------------------
// shse_front
// Accepts input words, holds the symbol width register and decodes symbol
// reads into word index, bit shift and mask.
// ----------------------------------------------------------------------------
`default_nettype none

module shse_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire shse_pkg::in_word_t in_word,
  input  wire logic               q_full,
  output logic                    push,
  output shse_pkg::cmd_t          push_cmd
);
  import shse_pkg::*;

  logic [4:0]  sym_bits_r;
  logic [4:0]  b;
  logic [6:0]  pw;
  logic [9:0]  rem;
  logic [9:0]  dvs;
  logic [2:0]  quo;
  logic [11:0] prod;
  logic [16:0] mask_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= SymBitsReset;
    end else if (cfg_valid) begin
      sym_bits_r <= cfg_data;
    end
  end

  always_comb begin
    if (sym_bits_r == 5'd0) begin
      b = 5'd1;
    end else if (sym_bits_r > SymBitsMax) begin
      b = SymBitsMax;
    end else begin
      b = sym_bits_r;
    end
  end

  assign pw = per_word(b);

  // three-step restoring divide; quotient known to be below 8 unless error
  always_comb begin
    rem = in_word.point_index;
    quo = '0;
    for (int k = 2; k >= 0; k--) begin
      dvs = 10'(pw) << k;
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[k] = 1'b1;
      end
    end
  end

  assign prod   = 12'(rem[6:0]) * 12'(b);
  assign mask_w = (17'd1 << b) - 17'd1;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.action   = in_word.action;
    push_cmd.seed     = in_word.seed;
    push_cmd.data     = in_word.data;
    push_cmd.err      = in_word.point_index >= {pw, 3'b000};
    push_cmd.word_ind = quo;
    push_cmd.shift    = prod[5:0];
    push_cmd.mask     = mask_w[15:0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/shse_queue.sv -----
// ----------------------------------------------------------------------------
// shse_queue
// Short command queue between the front decoder and the back engine.
// ----------------------------------------------------------------------------
`default_nettype none

module shse_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire shse_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output shse_pkg::cmd_t       pop_cmd,
  output logic                 empty
);
  import shse_pkg::*;

  cmd_t              mem_r [QDepth];
  logic [QAddrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAddrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAddrW:0]   count_r, count_nxt;

  assign full    = count_r == (QAddrW+1)'(QDepth);
  assign empty   = count_r == '0;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAddrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAddrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAddrW+1)'(QDepth))
    else $error("queue count over depth");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/shse_back.sv -----
// ----------------------------------------------------------------------------
// shse_back
// Round engine and stored words: runs the Salsa rounds one per cycle, keeps
// the hashed words and digest, extracts symbols and drives the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module shse_back #(
  parameter int DOUBLE_ROUNDS = shse_pkg::DoubleRoundsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire shse_pkg::cmd_t      q_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output shse_pkg::out_word_t      out_word
);
  import shse_pkg::*;

  localparam int Rounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW   = $clog2(Rounds);

  bk_state_t   state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  state_t      x_r, x_nxt;
  state_t      words_r, words_nxt;
  state_t      saved;
  state_t      sum;
  logic [63:0] digest_r, digest_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [31:0] data_r, data_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;
  logic        out_free;
  logic [63:0] sym_word;
  logic [63:0] sym_shift;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign saved = init_state(seed_r, data_r);
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sum[k] = x_r[k] + saved[k];
    end
  end

  assign sym_word  = {words_r[{q_cmd.word_ind, 1'b1}], words_r[{q_cmd.word_ind, 1'b0}]};
  assign sym_shift = sym_word >> q_cmd.shift;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    x_nxt         = x_r;
    words_nxt     = words_r;
    digest_nxt    = digest_r;
    seed_nxt      = seed_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    pop           = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.action == ActHash) begin
            pop       = 1'b1;
            seed_nxt  = q_cmd.seed;
            data_nxt  = q_cmd.data;
            x_nxt     = salsa_round(init_state(q_cmd.seed, q_cmd.data), 1'b0);
            rnd_nxt   = RndW'(1);
            state_nxt = BK_ROUND;
          end else if (out_free) begin
            pop                       = 1'b1;
            out_valid_nxt             = 1'b1;
            out_word_nxt.digest       = digest_r;
            out_word_nxt.index_error  = q_cmd.err;
            out_word_nxt.symbol       = q_cmd.err ? 16'd0 : (sym_shift[15:0] & q_cmd.mask);
          end
        end
      end
      BK_ROUND: begin
        x_nxt = salsa_round(x_r, rnd_r[0]);
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = BK_FINISH;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          words_nxt                = sum;
          digest_nxt               = fold_digest(sum);
          out_valid_nxt            = 1'b1;
          out_word_nxt.digest      = fold_digest(sum);
          out_word_nxt.symbol      = 16'd0;
          out_word_nxt.index_error = 1'b0;
          state_nxt                = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rnd_r       <= '0;
      words_r     <= '0;
      digest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      words_r     <= words_nxt;
      digest_r    <= digest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    seed_r     <= seed_nxt;
    data_r     <= data_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTH
  a_err_zero_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.index_error |-> out_word_r.symbol == 16'd0)
    else $error("symbol nonzero on index error");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE && !q_empty)
    else $error("queue popped while engine busy or queue empty");

  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_ROUND |-> rnd_r != '0 && rnd_r <= RndW'(Rounds - 1))
    else $error("round counter out of range");
`endif

endmodule

`default_nettype wire
